>>> rtl/core/dss_pkg.sv
// Package for the diagnostic slice scheduler: payload structs, codes, cell bus.
// No dependencies.
`default_nettype none
package dss_pkg;
  typedef enum logic [1:0] {FN_LOAD = 2'd0, FN_POLL = 2'd1, FN_REPORT = 2'd2} func_e;
  localparam logic [2:0] ACT_NONE = 3'd0;
  localparam logic [2:0] ACT_IO = 3'd1;
  localparam logic [2:0] ACT_DISPATCH = 3'd2;
  localparam logic [2:0] ACT_CHECK = 3'd3;
  localparam logic [2:0] ACT_REPORT = 3'd4;
  localparam logic [2:0] ACT_LOAD = 3'd5;
  localparam logic [1:0] SRC_NONE = 2'd0;
  localparam logic [1:0] SRC_OVERDUE = 2'd1;
  localparam logic [1:0] SRC_IO_LATE = 2'd2;
  localparam logic [1:0] SRC_BAD = 2'd3;
  localparam logic [0:0] REG_DISPATCH_INTERVAL = 1'd0;
  localparam logic [0:0] REG_CHECK_INTERVAL = 1'd1;
  // Test status codes; anything above loop complete is a bad outcome.
  localparam logic [1:0] ST_RUNNING = 2'd0;
  localparam logic [1:0] ST_LOOP_DONE = 2'd1;
  localparam logic [1:0] ST_OTHER = 2'd2;
  localparam logic [1:0] ST_OTHER_HIGH = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] system_time;
    logic        io_due;
    logic        io_check_ok;
    logic [3:0]  entry_index;
    logic [31:0] start_slice;
    logic [31:0] period_slices;
    logic [31:0] limit_slices;
    logic [1:0]  test_status;
    logic [31:0] run_time_us;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  test_index;
    logic        fault;
    logic [1:0]  fault_source;
    logic [31:0] worst_span;
    logic [31:0] current_slice;
  } out_item_t;

  // Token passed cell to cell during a sweep.
  typedef enum logic [2:0] {OP_IDLE = 3'd0, OP_PICK = 3'd1, OP_CHECK = 3'd2,
                            OP_BUMP = 3'd3} op_e;
  typedef struct packed {
    op_e         op;
    logic        found;    // pick: an earlier cell matched
    logic        overdue;  // check: some cell is overdue
    logic [31:0] slice;    // slice count for compares
  } tok_t;

  // Broadcast commands from the control to every cell.
  typedef struct packed {
    logic        load;     // load entry
    logic        advance;  // add step to trigger
    logic        done;     // loop complete record
    logic        dur;      // record duration
    logic [3:0]  sel;      // addressed cell
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } cmd_t;
endpackage
`default_nettype wire

>>> rtl/core/dss_cell.sv
// One test-table entry of the scheduler chain; registers its token to the next cell.
// Depends on dss_pkg.
`default_nettype none
module dss_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned IW = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire dss_pkg::cmd_t cmd,
  input  wire dss_pkg::tok_t tok_in,
  output dss_pkg::tok_t      tok_out,
  output logic [31:0]        step_o,
  output logic [31:0]        span_o
);
  import dss_pkg::*;
  logic [31:0] trig_r, step_r, lim_r, done_sl_r, max_r, dur_r;
  logic        once_r;
  tok_t        tok_r, tok_nxt;
  logic        me;
  logic [31:0] span;

  assign me = (cmd.sel == IW'(IDX));
  assign span = cmd.a - done_sl_r;

  always_comb begin
    tok_nxt = tok_in;
    unique case (tok_in.op)
      OP_PICK:  if (trig_r == tok_in.slice) tok_nxt.found = 1'b1;
      OP_CHECK: if ((tok_in.slice - done_sl_r) > lim_r) tok_nxt.overdue = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
      trig_r <= '0; step_r <= '0; lim_r <= '0; done_sl_r <= '0;
      max_r <= '0; dur_r <= '0; once_r <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
      // bump lower-priority entries sharing the old slice
      if (tok_in.op == OP_BUMP && IW'(IDX) > cmd.sel && trig_r == tok_in.slice)
        trig_r <= trig_r + 32'd1;
      if (me && cmd.load) begin
        trig_r <= cmd.a; step_r <= cmd.b; lim_r <= cmd.c;
        done_sl_r <= '0; max_r <= '0; dur_r <= '0; once_r <= 1'b0;
      end
      if (me && cmd.advance) trig_r <= trig_r + step_r;
      if (me && cmd.done) begin
        if (span > max_r && once_r) max_r <= span;
        once_r <= 1'b1;
        done_sl_r <= cmd.a;
      end
      if (me && cmd.dur) dur_r <= cmd.b;
    end
  end

  assign tok_out = tok_r;
  assign step_o = step_r;
  assign span_o = (me && cmd.done && span > max_r && once_r) ? span : max_r;
  // duration is kept as table state only
  logic unused_dur;
  assign unused_dur = ^dur_r;
endmodule
`default_nettype wire

>>> rtl/core/diagnostic_slice_scheduler_core.sv
// Top level of the diagnostic slice scheduler: control sequencer over a chain of cells.
// Depends on dss_pkg and dss_cell.
//
// Channel  Dir  Handshake            Payload
// in_      in   in_valid/in_ready    in_item_t
// out_     out  out_valid/out_ready  out_item_t
// cfg_     in   cfg_we               cfg_index, cfg_data
//
// One item at a time. A load, an idle or io poll and an ignored item go from
// the decode state straight to the finish state and then to the output state.
// A dispatching or checking poll and a taken report first sweep the token
// down the whole cell chain before the finish state.
// Reset is synchronous active low and clears all table state at once.
// The result sits in an output register; a stalled out_ready holds it and
// blocks the next transfer on the input.
`default_nettype none
module diagnostic_slice_scheduler_core #(
  parameter int unsigned NUM_TESTS = 10
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire dss_pkg::in_item_t in_item,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output dss_pkg::out_item_t     out_item,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [31:0]       cfg_data
);
  import dss_pkg::*;
  localparam int unsigned IW = 4;
  localparam int unsigned CW = $clog2(NUM_TESTS + 2);
  localparam logic [IW:0] NT_WIDE = (IW+1)'(NUM_TESTS);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_SWEEP = 4'b0010, S_FIN = 4'b0100, S_OUT = 4'b1000
  } state_t;

  state_t      state_r, state_nxt;
  logic [31:0] disp_iv_r, chk_iv_r;
  logic [31:0] slice_r, last_disp_r, last_chk_r;
  logic        await_r;
  logic [IW-1:0] pend_r;
  in_item_t    item_r;
  out_item_t   out_r, out_nxt;
  logic [CW-1:0] cnt_r;
  logic [IW-1:0] pick_r;
  logic        picked_r;
  op_e         sw_op_r;

  cmd_t        cmd;
  tok_t        tok [NUM_TESTS+1];
  logic [31:0] steps [NUM_TESTS];
  logic [31:0] spans [NUM_TESTS];

  // launch the token once the sweep op is latched
  assign tok[0].op = (state_r == S_SWEEP && cnt_r == CW'(1)) ? sw_op_r : OP_IDLE;
  assign tok[0].found = 1'b0;
  assign tok[0].overdue = 1'b0;
  assign tok[0].slice = slice_r;

  for (genvar g = 0; g < NUM_TESTS; g++) begin : g_cell
    dss_cell #(.IDX(g), .IW(IW)) u_cell (
      .clk, .rst_n, .cmd, .tok_in(tok[g]), .tok_out(tok[g+1]),
      .step_o(steps[g]), .span_o(spans[g]));
  end

  logic accept, poll_disp, poll_chk, sweep_req;
  logic [3:0] rep_k;
  assign in_ready = (state_r == S_IDLE);
  assign accept = in_valid && in_ready;
  assign rep_k = ({1'b0, pend_r} >= NT_WIDE) ? IW'(NUM_TESTS - 1) : pend_r;
  assign poll_disp = !item_r.io_due && !await_r &&
                     ((item_r.system_time - last_disp_r) > disp_iv_r);
  assign poll_chk = !item_r.io_due && !poll_disp &&
                    ((slice_r - last_chk_r) > chk_iv_r);
  assign sweep_req = (item_r.func == FN_POLL && (poll_disp || poll_chk)) ||
                     (item_r.func == FN_REPORT && await_r);

  // first matching cell during a pick sweep: tok[g] found clear, cell matched
  logic        hit;
  logic [IW-1:0] hit_idx;
  always_comb begin
    hit = 1'b0;
    hit_idx = '0;
    for (int g = 0; g < NUM_TESTS; g++)
      if (!hit && tok[g+1].op == OP_PICK && tok[g+1].found && !tok[g].found) begin
        hit = 1'b1;
        hit_idx = IW'(g);
      end
  end

  always_comb begin
    cmd = '0;
    cmd.a = item_r.start_slice;
    cmd.b = item_r.period_slices;
    cmd.c = item_r.limit_slices;
    cmd.sel = item_r.entry_index;
    if (state_r == S_FIN) begin
      unique case (item_r.func)
        FN_LOAD: cmd.load = ({1'b0, item_r.entry_index} < NT_WIDE);
        FN_POLL: begin
          cmd.sel = pick_r;
          cmd.advance = (sw_op_r == OP_PICK);
        end
        FN_REPORT: begin
          cmd.sel = rep_k;
          cmd.a = slice_r;
          cmd.b = item_r.run_time_us;
          cmd.done = await_r && item_r.test_status == ST_LOOP_DONE;
          cmd.dur = await_r && item_r.test_status <= ST_LOOP_DONE;
        end
        default: ;
      endcase
    end else if (state_r == S_SWEEP) begin
      cmd.sel = rep_k;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_SWEEP;
      S_SWEEP: if (cnt_r == '0 ? !sweep_req : cnt_r == CW'(NUM_TESTS)) state_nxt = S_FIN;
      S_FIN:   state_nxt = S_OUT;
      S_OUT:   if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      disp_iv_r <= 32'd1000; chk_iv_r <= 32'd100;
      slice_r <= '0; last_disp_r <= '0; last_chk_r <= '0;
      await_r <= 1'b0; pend_r <= '0; cnt_r <= '0;
      pick_r <= '0; picked_r <= 1'b0; sw_op_r <= OP_IDLE;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_index == REG_DISPATCH_INTERVAL) disp_iv_r <= cfg_data;
        else chk_iv_r <= cfg_data;
      end
      unique case (state_r)
        S_IDLE: begin
          cnt_r <= '0;
          picked_r <= 1'b0;
          pick_r <= IW'(NUM_TESTS - 1);
          sw_op_r <= OP_IDLE;
        end
        S_SWEEP: begin
          if (cnt_r == '0) begin
            // choose the sweep from the latched item
            if (item_r.func == FN_POLL && poll_disp) sw_op_r <= OP_PICK;
            else if (item_r.func == FN_POLL && poll_chk) sw_op_r <= OP_CHECK;
            else if (item_r.func == FN_REPORT && await_r) sw_op_r <= OP_BUMP;
            else sw_op_r <= OP_IDLE;
            if (sweep_req) cnt_r <= CW'(1);
          end else begin
            cnt_r <= cnt_r + CW'(1);
          end
          if (hit && !picked_r) begin
            picked_r <= 1'b1;
            pick_r <= hit_idx;
          end
        end
        default: ;
      endcase
      if (state_r == S_FIN && item_r.func == FN_POLL) begin
        if (sw_op_r == OP_PICK) begin
          last_disp_r <= item_r.system_time;
          pend_r <= pick_r;
          await_r <= 1'b1;
        end else if (sw_op_r == OP_CHECK) begin
          last_chk_r <= slice_r;
        end
      end
      if (state_r == S_FIN && item_r.func == FN_REPORT && await_r) begin
        await_r <= 1'b0;
        slice_r <= slice_r + 32'd1;
      end
    end
  end

  // The token is launched at count 1 with the chosen op and passes through each
  // cell's token register; the chain end holds it in the finish cycle, where the overdue flag is read.
  always_comb begin
    out_nxt = '0;
    out_nxt.current_slice = slice_r;
    unique case (item_r.func)
      FN_LOAD: if ({1'b0, item_r.entry_index} < NT_WIDE) out_nxt.action = ACT_LOAD;
      FN_POLL: begin
        if (item_r.io_due) out_nxt.action = ACT_IO;
        else if (sw_op_r == OP_PICK) begin
          out_nxt.action = ACT_DISPATCH;
          out_nxt.test_index = pick_r;
        end else if (sw_op_r == OP_CHECK) begin
          out_nxt.action = ACT_CHECK;
          if (tok[NUM_TESTS].overdue) begin
            out_nxt.fault = 1'b1;
            out_nxt.fault_source = SRC_OVERDUE;
          end else if (!item_r.io_check_ok) begin
            out_nxt.fault = 1'b1;
            out_nxt.fault_source = SRC_IO_LATE;
          end
        end
      end
      FN_REPORT: if (await_r) begin
        out_nxt.action = ACT_REPORT;
        out_nxt.test_index = rep_k;
        out_nxt.worst_span = spans[rep_k];
        out_nxt.current_slice = slice_r + 32'd1;
        if (item_r.test_status > ST_LOOP_DONE) begin
          out_nxt.fault = 1'b1;
          out_nxt.fault_source = SRC_BAD;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) item_r <= in_item;
    if (state_r == S_FIN) out_r <= out_nxt;
  end

  assign out_valid = (state_r == S_OUT);
  assign out_item = out_r;

  logic unused_steps;
  always_comb begin
    unused_steps = 1'b0;
    for (int g = 0; g < NUM_TESTS; g++) unused_steps = unused_steps ^ steps[g][0];
  end

  a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input open while result held");
  a_one_hot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not one-hot");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item)) else $error("result dropped");
endmodule
`default_nettype wire
